// ===== rtl/ffba_pkg.sv =====
`timescale 1ns / 1ps

package ffba_pkg;

	// command codes carried in the action field
	localparam logic [1:0] ACT_ALLOC   = 2'd0;
	localparam logic [1:0] ACT_FREE    = 2'd1;
	localparam logic [1:0] ACT_COMPACT = 2'd2;

	typedef struct packed {
		logic latch;     // capture a new item and rewind the scan
		logic scan_en;   // walk the slot store
		logic fill_en;   // run the write sweep (block fill, tail zeroing or the clear after reset)
		logic res_load;  // move the held result into the output register
	} ffba_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic fill_busy;
	} ffba_stat_t;

endpackage

// ===== rtl/first_fit_block_allocator_top.sv =====
`timescale 1ns / 1ps

// channel   dir  fields
// s_*       in   tdata: action[1:0] process_id[9:2] block_size[18:10]
// m_*       out  tdata: success[0] start_slot[8:1]
//
// one item at a time; the slot store has one write and one registered read port
// allocate: scan for a free run, then fill the block found; free: scan and clear the owner's run;
// compact: scan and pack the occupied slots down, then zero the tail
// after reset a clearing sweep writes all MEM_SLOTS slots, s_tready low until the sweep ends
// a new item is taken while the last result waits in the output register

module first_fit_block_allocator_top #(
	parameter int MEM_SLOTS = 256,
	parameter int ID_BITS   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // action[1:0], process_id[9:2], block_size[18:10]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // success[0], start_slot[8:1]
);
	import ffba_pkg::*;

	ffba_cmd_t  cmd;
	ffba_stat_t stat;
	logic       out_success;
	logic [7:0] out_start;

	ffba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	ffba_datapath #(
		.MEM_SLOTS (MEM_SLOTS),
		.ID_BITS   (ID_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_action   (s_tdata[1:0]),
		.in_id       (s_tdata[9:2]),
		.in_size     (s_tdata[18:10]),
		.out_success (out_success),
		.out_start   (out_start)
	);

	assign m_tdata = {7'b0, out_start, out_success};

	// one item in flight
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("item accepted while another is at work");

	// result register is only reloaded once the old result has left
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!m_tvalid || m_tready))
		else $error("pending result overwritten");

	// failed commands report slot zero
	a_fail_start: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tdata[8:1] == 8'd0))
		else $error("nonzero start slot on failure");

endmodule

// ===== rtl/ffba_ctrl.sv =====
`timescale 1ns / 1ps

module ffba_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output ffba_pkg::ffba_cmd_t  cmd,
	input  ffba_pkg::ffba_stat_t stat
);
	import ffba_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_FILL  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd.latch    = (state_q == ST_IDLE) && s_tvalid;
		cmd.scan_en  = (state_q == ST_SCAN);
		cmd.fill_en  = (state_q == ST_FILL) || (state_q == ST_CLEAR);
		cmd.res_load = (state_q == ST_DONE) && (!out_valid_q || m_tready);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (!stat.fill_busy) state_d = ST_IDLE;
			ST_IDLE:  if (s_tvalid) state_d = ST_SCAN;
			ST_SCAN:  if (stat.scan_done) state_d = ST_FILL;
			ST_FILL:  if (!stat.fill_busy) state_d = ST_DONE;
			ST_DONE:  if (cmd.res_load) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/ffba_datapath.sv =====
`timescale 1ns / 1ps

module ffba_datapath #(
	parameter int MEM_SLOTS = 256,
	parameter int ID_BITS   = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ffba_pkg::ffba_cmd_t  cmd,
	output ffba_pkg::ffba_stat_t stat,
	input  logic [1:0]           in_action,
	input  logic [7:0]           in_id,
	input  logic [8:0]           in_size,
	output logic                 out_success,
	output logic [7:0]           out_start
);
	import ffba_pkg::*;

	localparam int AW = (MEM_SLOTS > 1) ? $clog2(MEM_SLOTS) : 1;
	localparam int CW = $clog2(MEM_SLOTS + 1);
	localparam int SW = ((CW > 9) ? CW : 9) + 1;
	localparam logic [CW-1:0] SLOT_END  = CW'(MEM_SLOTS);
	localparam logic [AW-1:0] SLOT_LAST = AW'(MEM_SLOTS - 1);

	logic [ID_BITS-1:0] mem [MEM_SLOTS];

	logic [1:0]         op_q;
	logic [ID_BITS-1:0] id_q;
	logic [8:0]         size_q;
	logic [CW-1:0]      rd_q;
	logic               rv_s1;
	logic [AW-1:0]      ev_s1;
	logic [ID_BITS-1:0] rdata_s1;
	logic [CW-1:0]      run_q;
	logic [AW-1:0]      start_q;
	logic               found_q;
	logic [CW-1:0]      j_q;
	logic [CW-1:0]      wa_q;
	logic [CW-1:0]      fend_q;
	logic [ID_BITS-1:0] fdat_q;
	logic               res_hit_q;
	logic [AW-1:0]      res_start_q;
	logic               out_success_q;
	logic [7:0]         out_start_q;

	logic [ID_BITS+7:0] id_ext;
	logic [ID_BITS-1:0] id_in;
	logic               skip;
	logic               issue;
	logic [AW-1:0]      raddr;
	logic               eval;
	logic               slot_free;
	logic               id_match;
	logic [AW-1:0]      run_start;
	logic [CW-1:0]      run_next;
	logic               run_fit;
	logic               last;
	logic               fill_busy;
	logic               stop;
	logic               hit_now;
	logic [AW-1:0]      st_now;
	logic               done;
	logic               we;
	logic [AW-1:0]      waddr;
	logic [ID_BITS-1:0] wdata;
	logic [AW+7:0]      start_ext;

	// owner id keeps only ID_BITS of the incoming field
	assign id_ext = {{ID_BITS{1'b0}}, in_id};
	assign id_in  = id_ext[ID_BITS-1:0];

	assign skip = ((op_q != ACT_ALLOC) && (op_q != ACT_FREE) && (op_q != ACT_COMPACT))
		|| ((op_q != ACT_COMPACT) && (id_q == '0));

	assign issue     = cmd.scan_en && (rd_q != SLOT_END);
	assign raddr     = issue ? rd_q[AW-1:0] : '0;
	assign eval      = cmd.scan_en && rv_s1;
	assign slot_free = (rdata_s1 == '0);
	assign id_match  = (rdata_s1 == id_q);
	assign run_start = (run_q == '0) ? ev_s1 : start_q;
	assign run_next  = run_q + CW'(1);
	assign run_fit   = SW'(run_next) >= SW'(size_q);
	assign last      = (ev_s1 == SLOT_LAST);
	assign fill_busy = (wa_q != fend_q);

	always_comb begin
		stop    = 1'b0;
		hit_now = 1'b0;
		st_now  = ev_s1;
		we      = 1'b0;
		waddr   = ev_s1;
		wdata   = '0;
		priority if (cmd.fill_en && fill_busy) begin
			we    = 1'b1;
			waddr = wa_q[AW-1:0];
			wdata = fdat_q;
		end else if (eval) begin
			unique case (op_q)
				ACT_ALLOC: begin
					if (slot_free && (size_q == '0)) begin
						hit_now = 1'b1;
						stop    = 1'b1;
					end else if (slot_free && run_fit) begin
						hit_now = 1'b1;
						stop    = 1'b1;
						st_now  = run_start;
					end
				end
				ACT_FREE: begin
					hit_now = found_q || id_match;
					st_now  = found_q ? start_q : ev_s1;
					// the cleared run ends at the first slot not held by this owner
					stop    = found_q && !id_match;
					we      = id_match;
				end
				ACT_COMPACT: begin
					hit_now = 1'b1;
					st_now  = '0;
					// each occupied slot is copied down to the write pointer
					we      = !slot_free;
					waddr   = j_q[AW-1:0];
					wdata   = rdata_s1;
				end
				default: ;
			endcase
		end else begin
		end
	end

	assign done = cmd.scan_en && (skip || (eval && (stop || last)));

	always_comb begin
		stat.scan_done = done;
		stat.fill_busy = fill_busy;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q          <= ACT_ALLOC;
			id_q          <= '0;
			size_q        <= '0;
			rd_q          <= '0;
			rv_s1         <= 1'b0;
			ev_s1         <= '0;
			run_q         <= '0;
			start_q       <= '0;
			found_q       <= 1'b0;
			j_q           <= '0;
			wa_q          <= '0;
			fend_q        <= SLOT_END;
			fdat_q        <= '0;
			res_hit_q     <= 1'b0;
			res_start_q   <= '0;
			out_success_q <= 1'b0;
			out_start_q   <= '0;
		end else begin
			rv_s1 <= issue;
			ev_s1 <= rd_q[AW-1:0];
			if (cmd.latch) begin
				op_q    <= in_action;
				id_q    <= id_in;
				size_q  <= in_size;
				rd_q    <= '0;
				run_q   <= '0;
				found_q <= 1'b0;
				j_q     <= '0;
			end else if (cmd.scan_en) begin
				if (issue) begin
					rd_q <= rd_q + CW'(1);
				end
				if (eval) begin
					unique case (op_q)
						ACT_ALLOC: begin
							if (slot_free) begin
								run_q   <= run_next;
								start_q <= run_start;
							end else begin
								run_q <= '0;
							end
						end
						ACT_FREE: begin
							if (id_match && !found_q) begin
								found_q <= 1'b1;
								start_q <= ev_s1;
							end
						end
						ACT_COMPACT: begin
							if (!slot_free) begin
								j_q <= j_q + CW'(1);
							end
						end
						default: ;
					endcase
				end
			end
			if (done) begin
				res_hit_q   <= !skip && hit_now;
				res_start_q <= (!skip && hit_now) ? st_now : '0;
				if (!skip && (op_q == ACT_ALLOC) && hit_now && (size_q != '0)) begin
					wa_q   <= CW'(st_now);
					fend_q <= CW'(st_now) + CW'(size_q);
					fdat_q <= id_q;
				end else if (!skip && (op_q == ACT_COMPACT)) begin
					// zero the tail behind the packed slots
					wa_q   <= slot_free ? j_q : (j_q + CW'(1));
					fend_q <= SLOT_END;
					fdat_q <= '0;
				end else begin
					wa_q   <= '0;
					fend_q <= '0;
				end
			end else if (cmd.fill_en && fill_busy) begin
				wa_q <= wa_q + CW'(1);
			end
			if (cmd.res_load) begin
				out_success_q <= res_hit_q;
				out_start_q   <= start_ext[7:0];
			end
		end
	end

	assign start_ext   = {8'b0, res_start_q};
	assign out_success = out_success_q;
	assign out_start   = out_start_q;

endmodule
